// ===== sv/xsrgb_pkg.sv =====
package xsrgb_pkg;

  // input and output words
  typedef struct packed {
    logic [15:0] x_in;
    logic [15:0] y_in;
    logic [15:0] z_in;
  } xyz_word_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } srgb_word_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  localparam int NUM_CH = 3;

  // linear value in q16, 65536 is one
  localparam int LIN_W = 17;
  localparam logic [LIN_W-1:0] LIN_ONE = 17'd65536;

  // knee of the transfer curve
  localparam logic [LIN_W-1:0] KNEE_LIN_MAX = 17'd205;
  localparam logic [15:0] KNEE_CODE = 16'd2651;
  localparam int LIN_CODE_W = 12;

  // knot code scaling: codes per unit of 1.055 * x^(5/12) in q20, and half of it
  localparam logic signed [63:0] KNOT_DIV  = 64'sd1000 * 64'sd1048576;
  localparam logic signed [63:0] KNOT_HALF = 64'sd500 * 64'sd1048576;

  // sRGB matrix, signed q14, rows r g b
  localparam logic signed [16:0] MTX [NUM_CH][NUM_CH] = '{
    '{ 17'sd53094, -17'sd25185, -17'sd8169 },
    '{ -17'sd15874, 17'sd30733, 17'sd680 },
    '{ 17'sd913, -17'sd3342, 17'sd17318 }
  };

  // floor square root, argument below 2**62
  function automatic logic [63:0] root2(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  // floor cube root, argument below 2**62
  function automatic logic [63:0] root3(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 20; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  // curve code at x, x given in q30
  function automatic logic [15:0] knot_code(input logic [63:0] x30);
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] w;
    logic [63:0] r;
    logic signed [63:0] num;
    logic signed [63:0] code;
    s = root2(x30 << 30);
    q = root2(s << 30);
    w = (x30 * q) >> 30;
    r = root3(w << 30);
    num = $signed(64'd1055 * r * 64'd65535) - (64'sd55 * 64'sd65535 * 64'sd1048576);
    if (num <= 0) begin
      code = '0;
    end else begin
      code = (num + KNOT_HALF) / KNOT_DIV;
      if (code > 64'sd65535) code = 64'sd65535;
    end
    return code[15:0];
  endfunction

  // code of the straight segment below the knee
  function automatic logic [LIN_CODE_W-1:0] lin_code(input logic [63:0] l);
    logic [63:0] v;
    v = (l * 64'd1292 * 64'd65535 + 64'd3276800) / 64'd6553600;
    return v[LIN_CODE_W-1:0];
  endfunction

endpackage

// ===== sv/xsrgb_matrix.sv =====
module xsrgb_matrix (
  input  logic                               clk,
  input  xsrgb_pkg::pipe_en_t                en,
  input  xsrgb_pkg::xyz_word_t               pix,
  output logic [xsrgb_pkg::LIN_W-1:0]        lin [xsrgb_pkg::NUM_CH]
);
  import xsrgb_pkg::*;

  logic signed [16:0] xyz [NUM_CH];
  logic signed [33:0] prod [NUM_CH][NUM_CH];
  logic signed [35:0] sum [NUM_CH];
  logic signed [35:0] rnd [NUM_CH];
  logic [LIN_W-1:0]   lin_next [NUM_CH];

  assign xyz[0] = $signed({1'b0, pix.x_in});
  assign xyz[1] = $signed({1'b0, pix.y_in});
  assign xyz[2] = $signed({1'b0, pix.z_in});

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int r = 0; r < NUM_CH; r++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          prod[r][c] <= MTX[r][c] * xyz[c];
        end
      end
    end
  end

  // row sums, rounding to q16 and clamping to [0,1]
  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      sum[r] = 36'(prod[r][0]) + 36'(prod[r][1]) + 36'(prod[r][2]);
      rnd[r] = (sum[r] + 36'sd2048) >>> 12;
      if (sum[r] <= 36'sd0) begin
        lin_next[r] = '0;
      end else if (rnd[r] > 36'sd65536) begin
        lin_next[r] = LIN_ONE;
      end else begin
        lin_next[r] = rnd[r][LIN_W-1:0];
      end
    end
  end

  // stage 2: linear channel values
  always_ff @(posedge clk) begin
    if (en.s2) begin
      lin <= lin_next;
    end
  end

endmodule

// ===== sv/xsrgb_gamma.sv =====
module xsrgb_gamma #(
  parameter int GAMMA_SEGMENTS = 64
) (
  input  logic                        clk,
  input  xsrgb_pkg::pipe_en_t         en,
  input  logic [xsrgb_pkg::LIN_W-1:0] lin,
  output logic [15:0]                 code
);
  import xsrgb_pkg::*;

  localparam int AW = $clog2(GAMMA_SEGMENTS);
  localparam int SW = $clog2(GAMMA_SEGMENTS + 1);
  localparam int PW = LIN_W + SW;
  localparam logic [63:0] X_TOP = (64'(GAMMA_SEGMENTS) << 30) / GAMMA_SEGMENTS;
  localparam logic [15:0] KNOT_TOP = knot_code(X_TOP);

  // knot pairs {upper, lower} per segment, spare rows read as zero
  logic [31:0]           knot_rom [2**AW];
  logic [LIN_CODE_W-1:0] lin_tab [256];

  for (genvar i = 0; i < 2**AW; i++) begin : g_knot
    if (i < GAMMA_SEGMENTS) begin : g_used
      localparam logic [63:0] X_LO = (64'(i) << 30) / GAMMA_SEGMENTS;
      localparam logic [63:0] X_HI = (64'(i + 1) << 30) / GAMMA_SEGMENTS;
      localparam logic [15:0] K_LO = (i == 0) ? KNEE_CODE : knot_code(X_LO);
      localparam logic [15:0] K_HI = knot_code(X_HI);
      assign knot_rom[i] = {K_HI, K_LO};
    end else begin : g_spare
      assign knot_rom[i] = '0;
    end
  end

  for (genvar j = 0; j < 256; j++) begin : g_lin
    if (j <= 205) begin : g_used
      localparam logic [LIN_CODE_W-1:0] L_CODE = lin_code(64'(j));
      assign lin_tab[j] = L_CODE;
    end else begin : g_spare
      assign lin_tab[j] = '0;
    end
  end

  // segment index and fraction
  logic [PW-1:0] pos;
  logic [AW-1:0] idx;
  assign pos = PW'(lin) * PW'(GAMMA_SEGMENTS);
  assign idx = pos[16 +: AW];

  // stage 3: table read and branch choice
  logic [31:0]           row;
  logic [15:0]           frac;
  logic                  lin_sel3;
  logic                  sat_sel3;
  logic [LIN_CODE_W-1:0] lin_val3;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      row      <= knot_rom[idx];
      frac     <= pos[15:0];
      lin_sel3 <= (lin <= KNEE_LIN_MAX);
      sat_sel3 <= (lin == LIN_ONE);
      lin_val3 <= lin_tab[lin[7:0]];
    end
  end

  // stage 4: slope times fraction
  logic signed [16:0]    slope;
  logic [15:0]           base4;
  logic signed [33:0]    delta;
  logic                  lin_sel4;
  logic                  sat_sel4;
  logic [LIN_CODE_W-1:0] lin_val4;

  assign slope = $signed({1'b0, row[31:16]}) - $signed({1'b0, row[15:0]});

  always_ff @(posedge clk) begin
    if (en.s4) begin
      base4    <= row[15:0];
      delta    <= slope * $signed({1'b0, frac});
      lin_sel4 <= lin_sel3;
      sat_sel4 <= sat_sel3;
      lin_val4 <= lin_val3;
    end
  end

  // stage 5: round, add base and select branch
  logic signed [33:0] delta_rnd;
  logic signed [17:0] interp;
  logic [15:0]        code_next;

  assign delta_rnd = delta + 34'sd32768;
  assign interp    = $signed({2'b00, base4}) + delta_rnd[33:16];

  always_comb begin
    priority if (lin_sel4) begin
      code_next = 16'(lin_val4);
    end else if (sat_sel4) begin
      code_next = KNOT_TOP;
    end else begin
      code_next = interp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      code <= code_next;
    end
  end

endmodule

// ===== sv/xyz_to_srgb_pixel_top.sv =====
// an accepted word passes stages one to five in order; out_valid rises when it reaches
// stage five, and its way out is delayed only while out_stall holds
// throughput: one pixel per cycle while no result is held, five register stages that each take a word per cycle
// stages: matrix products, row sums, knot table read, slope multiply, interpolation
// out_stall reaches in_stall in the same cycle through the ready chain, and empty
// stages keep filling behind a held result
// reset clears the stage valid bits only; the knot table is constant and needs no fill
module xyz_to_srgb_pixel_top #(
  parameter int GAMMA_SEGMENTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  xsrgb_pkg::xyz_word_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output xsrgb_pkg::srgb_word_t  out_data
);
  import xsrgb_pkg::*;

  logic [5:1] vld;
  logic [5:1] rdy;
  pipe_en_t   en;

  // a stage can load when it is empty or its word moves on
  assign rdy[5] = !vld[5] || !out_stall;
  assign rdy[4] = !vld[4] || rdy[5];
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];

  assign en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

  assign in_stall  = !rdy[1];
  assign out_valid = vld[5];

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= in_valid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
    end
  end

  logic [LIN_W-1:0] lin [NUM_CH];
  logic [15:0]      code [NUM_CH];

  xsrgb_matrix u_matrix (
    .clk (clk),
    .en  (en),
    .pix (in_data),
    .lin (lin)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    xsrgb_gamma #(
      .GAMMA_SEGMENTS (GAMMA_SEGMENTS)
    ) u_gamma (
      .clk  (clk),
      .en   (en),
      .lin  (lin[c]),
      .code (code[c])
    );
  end

  assign out_data = '{red_out: code[0], green_out: code[1], blue_out: code[2]};

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[1])
    else $error("accepted word not captured by first stage");

  // with no result waiting the whole pipe can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

  // a word in stage four reaches the output when the output can take it
  a_last_advance: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !(vld[5] && out_stall) |=> out_valid)
    else $error("word lost between interpolation stages");

  // a held result is only dropped by a completed handshake
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && vld[4] |=> out_valid && vld[4])
    else $error("pipe advanced under output stall");

endmodule
